// ===== rtl/hrs_pkg.sv =====
// Shared constants, types and helper functions of the height relief shader.
`default_nettype none
package hrs_pkg;

    localparam int TILE_WIDTH   = 512;
    localparam int COL_W        = $clog2(TILE_WIDTH);

    localparam int HEIGHT_W     = 12;
    localparam int COLOR_W      = 24;
    localparam int DEPTH_W      = 8;
    localparam int BLOCK_W      = 16;
    localparam int FACTOR_W     = 9;
    localparam int PIXEL_W      = 32;
    localparam int DPROD_W      = 12;

    localparam int FLOOR_FACTOR = 120;
    localparam int DEPTH_STEP   = 9;
    localparam int FULL_FACTOR  = 256;
    localparam int LEVEL_FACTOR = 220;
    localparam int LOW_FACTOR   = 180;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [FACTOR_W-1:0] t_factor;

    // North row entry: valid flag above the raw height bits.
    typedef struct packed {
        logic                       valid;
        logic [HEIGHT_W-1:0]        height;
    } t_north;

    // One classified column waiting for the shading stage.
    typedef struct packed {
        logic                       present;
        t_factor                    factor;
        logic [COLOR_W-1:0]         color;
        logic [HEIGHT_W-1:0]        height;
        logic [BLOCK_W-1:0]         block;
    } t_entry;

    // Scales one color channel by a factor in units of 1/256.
    function automatic logic [7:0] shade_channel(input logic [7:0] ch, input t_factor factor);
        logic [7+FACTOR_W:0] prod;
        prod = {{FACTOR_W{1'b0}}, ch} * {8'd0, factor};
        return prod[15:8];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hrs_front.sv =====
// Front end: column tracking, north row store and shade factor selection.
`default_nettype none
module hrs_front
    import hrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_tile_start,
    input  wire logic                  i_has_surface,
    input  wire logic [HEIGHT_W-1:0]   i_surface_height,
    input  wire logic [COLOR_W-1:0]    i_base_color,
    input  wire logic [DEPTH_W-1:0]    i_water_depth,
    input  wire logic [BLOCK_W-1:0]    i_block_id,
    output logic                       o_push_valid,
    input  wire logic                  i_push_ready,
    output t_entry                     o_push_data
);

    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic                r_first;
    logic                n_first;
    logic [COL_W-1:0]    cur_col;
    logic                cur_first;
    logic                accept;

    t_north              r_mem [TILE_WIDTH];
    t_north              r_north;

    logic                r_s1_valid;
    logic                r_s1_first;
    logic                r_s1_present;
    logic [HEIGHT_W-1:0] r_s1_height;
    logic [COLOR_W-1:0]  r_s1_color;
    logic [DEPTH_W-1:0]  r_s1_depth;
    logic [BLOCK_W-1:0]  r_s1_block;

    logic [DPROD_W-1:0]  depth_prod;
    logic [DPROD_W-1:0]  depth_left;
    logic signed [HEIGHT_W-1:0] h_self;
    logic signed [HEIGHT_W-1:0] h_north;
    t_factor             factor;

    assign o_ready   = !r_s1_valid || i_push_ready;
    assign accept    = i_valid && o_ready;
    assign cur_col   = i_tile_start ? '0 : r_col;
    assign cur_first = i_tile_start ? 1'b1 : r_first;

    always_comb begin
        n_col   = r_col;
        n_first = r_first;
        if (accept) begin
            if (cur_col == COL_W'(TILE_WIDTH - 1)) begin
                n_col   = '0;
                n_first = 1'b0;
            end else begin
                n_col   = cur_col + 1'b1;
                n_first = cur_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

    // The read returns the entry left by the previous row before this beat overwrites it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_north      <= r_mem[cur_col];
            r_mem[cur_col] <= '{valid: i_has_surface, height: i_surface_height};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_first   <= cur_first;
            r_s1_present <= i_has_surface;
            r_s1_height  <= i_surface_height;
            r_s1_color   <= i_base_color;
            r_s1_depth   <= i_water_depth;
            r_s1_block   <= i_block_id;
        end
    end

    assign depth_prod = DPROD_W'(DEPTH_STEP) * {{(DPROD_W-DEPTH_W){1'b0}}, r_s1_depth};
    assign depth_left = DPROD_W'(FULL_FACTOR) - depth_prod;
    assign h_self     = $signed(r_s1_height);
    assign h_north    = (!r_s1_first && r_north.valid) ? $signed(r_north.height) : h_self;

    always_comb begin
        if (r_s1_depth != '0) begin
            if (depth_prod > DPROD_W'(FULL_FACTOR - FLOOR_FACTOR)) begin
                factor = FACTOR_W'(FLOOR_FACTOR);
            end else begin
                factor = depth_left[FACTOR_W-1:0];
            end
        end else if (h_self > h_north) begin
            factor = FACTOR_W'(FULL_FACTOR);
        end else if (h_self == h_north) begin
            factor = FACTOR_W'(LEVEL_FACTOR);
        end else begin
            factor = FACTOR_W'(LOW_FACTOR);
        end
    end

    assign o_push_valid = r_s1_valid;
    assign o_push_data  = '{present: r_s1_present, factor: factor, color: r_s1_color,
                            height: r_s1_height, block: r_s1_block};

endmodule
`default_nettype wire

// ===== rtl/hrs_queue.sv =====
// Short queue of classified columns between the front end and the shading stage.
`default_nettype none
module hrs_queue
    import hrs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push_valid,
    output logic        o_push_ready,
    input  wire t_entry i_push_data,
    output logic        o_pop_valid,
    input  wire logic   i_pop_ready,
    output t_entry      o_pop_data
);

    t_entry              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                push;
    logic                pop;

    assign o_push_ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hrs_back.sv =====
// Shading stage: per-channel scaling and the registered result beat.
`default_nettype none
module hrs_back
    import hrs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_pop_valid,
    output logic                      o_pop_ready,
    input  wire t_entry               i_pop_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [PIXEL_W-1:0]        o_pixel_argb,
    output logic                      o_height_valid,
    output logic [HEIGHT_W-1:0]       o_height_out,
    output logic [BLOCK_W-1:0]        o_block_out
);

    logic                 r_valid;
    logic [PIXEL_W-1:0]   r_pixel;
    logic                 r_hvalid;
    logic [HEIGHT_W-1:0]  r_height;
    logic [BLOCK_W-1:0]   r_block;
    logic                 take;
    logic [PIXEL_W-1:0]   shaded;

    assign o_pop_ready = !r_valid || i_ready;
    assign take        = i_pop_valid && o_pop_ready;

    assign shaded = {ALPHA_OPAQUE,
                     shade_channel(i_pop_data.color[23:16], i_pop_data.factor),
                     shade_channel(i_pop_data.color[15:8],  i_pop_data.factor),
                     shade_channel(i_pop_data.color[7:0],   i_pop_data.factor)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hvalid <= i_pop_data.present;
            r_pixel  <= i_pop_data.present ? shaded : '0;
            r_height <= i_pop_data.present ? i_pop_data.height : '0;
            r_block  <= i_pop_data.present ? i_pop_data.block : '0;
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel_argb   = r_pixel;
    assign o_height_valid = r_hvalid;
    assign o_height_out   = r_height;
    assign o_block_out    = r_block;

endmodule
`default_nettype wire

// ===== rtl/height_relief_shader.sv =====
// Top level of the height relief shader: front end, queue and shading stage.
//
// The height relief shader turns a raster stream of map columns into hillshaded
// ARGB pixels, one result beat for every input beat, at a sustained rate of one
// beat per clock while the output is not stalled. A beat with tile_start set
// restarts the column and row count, so dry ground in the first row of each tile
// is shaded as level. The front end keeps the previous row's heights in a
// single-port line store of TILE_WIDTH entries; each column reads its northern
// neighbor and writes its own height in the same cycle, and that one access per
// column sets the rate. The shade factor is chosen in the front end, and the
// three color channels are scaled by parallel multipliers in the shading stage.
// An accepted input beat passes through the front end register, then the queue,
// into the output register, where its result becomes valid. A two-entry queue
// between the front end and the shading stage, plus the output register, lets
// the input keep flowing while a finished result waits to be taken. The line
// store needs no clearing after reset, since the first row never consults it.
`default_nettype none
module height_relief_shader
    import hrs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_tile_start,
    input  wire logic                 i_has_surface,
    input  wire logic [HEIGHT_W-1:0]  i_surface_height,
    input  wire logic [COLOR_W-1:0]   i_base_color,
    input  wire logic [DEPTH_W-1:0]   i_water_depth,
    input  wire logic [BLOCK_W-1:0]   i_block_id,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [PIXEL_W-1:0]        o_pixel_argb,
    output logic                      o_height_valid,
    output logic [HEIGHT_W-1:0]       o_height_out,
    output logic [BLOCK_W-1:0]        o_block_out
);

    // Classified columns travel from the front end into the queue.
    logic   push_valid;
    logic   push_ready;
    t_entry push_data;

    // The shading stage drains the queue whenever its output register is free.
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_data;

    hrs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_tile_start     (i_tile_start),
        .i_has_surface    (i_has_surface),
        .i_surface_height (i_surface_height),
        .i_base_color     (i_base_color),
        .i_water_depth    (i_water_depth),
        .i_block_id       (i_block_id),
        .o_push_valid     (push_valid),
        .i_push_ready     (push_ready),
        .o_push_data      (push_data)
    );

    hrs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    hrs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (pop_valid),
        .o_pop_ready    (pop_ready),
        .i_pop_data     (pop_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_argb   (o_pixel_argb),
        .o_height_valid (o_height_valid),
        .o_height_out   (o_height_out),
        .o_block_out    (o_block_out)
    );

endmodule
`default_nettype wire

// ===== bench/height_relief_shader_test.sv =====
// Self-checking testbench for the height relief shader: streams map columns and checks every pixel.
`timescale 1ns / 1ps

module height_relief_shader_test;
    import hrs_pkg::*;

    // A run with no accepted beat on either side for this many cycles has hung.
    localparam int STALL_LIMIT   = 400;
    // Random columns after the directed part. This is enough to finish the first
    // row of the tile and go well into the second row, where the north compare
    // is actually exercised.
    localparam int RANDOM_COLUMNS = 640;
    // Cycles to wait at the end, after every predicted pixel has come out.
    localparam int SETTLE_CYCLES  = 8;

    // Receiver stall patterns. The sink switches among them every so often.
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_COMB,
        SINK_CHOKE
    } t_sink_mode;

    // One map column as it is presented on the input channel.
    typedef struct {
        bit                         start;
        bit                         present;
        logic signed [HEIGHT_W-1:0] height;
        logic [COLOR_W-1:0]         color;
        logic [DEPTH_W-1:0]         depth;
        logic [BLOCK_W-1:0]         block;
    } t_column;

    // One shaded pixel as it should come out of the block.
    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel;
        logic                hvalid;
        logic [HEIGHT_W-1:0] height;
        logic [BLOCK_W-1:0]  block;
    } t_shaded;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                i_tile_start     = 1'b0;
    logic                i_has_surface    = 1'b0;
    logic [HEIGHT_W-1:0] i_surface_height = '0;
    logic [COLOR_W-1:0]  i_base_color     = '0;
    logic [DEPTH_W-1:0]  i_water_depth    = '0;
    logic [BLOCK_W-1:0]  i_block_id       = '0;
    logic                i_ready          = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [PIXEL_W-1:0]  o_pixel_argb;
    logic                o_height_valid;
    logic [HEIGHT_W-1:0] o_height_out;
    logic [BLOCK_W-1:0]  o_block_out;

    // Shading predictor state: the previous row's heights, the column within the
    // row, and whether the current row is the first one of the tile.
    t_north north_heights [TILE_WIDTH];
    int     col_pos;
    bit     in_first_row;

    // Pixels predicted for accepted columns, oldest first.
    t_shaded expected_pixels [$];

    int         mismatch_count = 0;
    int         idle_cycles    = 0;
    int         burst_left     = 0;
    t_sink_mode sink_mode      = SINK_OPEN;
    int         sink_cycles_left = 0;
    int         sink_phase     = 0;

    height_relief_shader u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_tile_start     (i_tile_start),
        .i_has_surface    (i_has_surface),
        .i_surface_height (i_surface_height),
        .i_base_color     (i_base_color),
        .i_water_depth    (i_water_depth),
        .i_block_id       (i_block_id),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pixel_argb     (o_pixel_argb),
        .o_height_valid   (o_height_valid),
        .o_height_out     (o_height_out),
        .o_block_out      (o_block_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Scales one color channel by a factor given in units of 1/256.
    function automatic logic [7:0] scaled(input logic [7:0] channel, input int factor);
        return 8'((int'(channel) * factor) >> 8);
    endfunction

    function automatic t_column make_column(input bit start, input bit present, input int height,
                                            input int color, input int depth, input int block);
        t_column c;
        c.start   = start;
        c.present = present;
        c.height  = height[HEIGHT_W-1:0];
        c.color   = color[COLOR_W-1:0];
        c.depth   = depth[DEPTH_W-1:0];
        c.block   = block[BLOCK_W-1:0];
        return c;
    endfunction

    // Works out the pixel for one accepted column and advances the row state.
    // Water hides the terrain, so under water only the depth matters. On dry
    // ground the column is compared with the one directly north of it; in the
    // first row of a tile, or when the northern column was empty, the ground
    // counts as level.
    task automatic relief_shade(input t_column c);
        int                         col;
        int                         factor;
        logic signed [HEIGHT_W-1:0] north_h;
        t_shaded                    res;
        if (c.start) begin
            col_pos      = 0;
            in_first_row = 1'b1;
        end
        col = col_pos;
        res = '0;
        if (c.present) begin
            if (c.depth != 0) begin
                factor = FULL_FACTOR - DEPTH_STEP * int'(c.depth);
                if (factor < FLOOR_FACTOR) begin
                    factor = FLOOR_FACTOR;
                end
            end else begin
                north_h = c.height;
                if (!in_first_row && north_heights[col].valid) begin
                    north_h = signed'(north_heights[col].height);
                end
                if (c.height > north_h) begin
                    factor = FULL_FACTOR;
                end else if (c.height == north_h) begin
                    factor = LEVEL_FACTOR;
                end else begin
                    factor = LOW_FACTOR;
                end
            end
            res.pixel  = {ALPHA_OPAQUE, scaled(c.color[23:16], factor),
                          scaled(c.color[15:8], factor), scaled(c.color[7:0], factor)};
            res.hvalid = 1'b1;
            res.height = c.height;
            res.block  = c.block;
            north_heights[col] = {1'b1, c.height};
        end else begin
            north_heights[col] = '0;
        end
        if (col == TILE_WIDTH - 1) begin
            col_pos      = 0;
            in_first_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end
        expected_pixels = {expected_pixels, res};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    // Sends one column. The sender works in bursts: when a burst runs out, valid
    // drops for a short random gap before the next burst starts. Some bursts are
    // long, which gives stretches with no idling at all.
    task automatic send_column(input t_column c);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                    : $urandom_range(40, 120);
        end
        i_valid          <= 1'b1;
        i_tile_start     <= c.start;
        i_has_surface    <= c.present;
        i_surface_height <= c.height;
        i_base_color     <= c.color;
        i_water_depth    <= c.depth;
        i_block_id       <= c.block;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        relief_shade(c);
        burst_left--;
    endtask

    // Stops sending until every predicted pixel has come out.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    task automatic test_reset();
        col_pos      = 0;
        in_first_row = 1'b1;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Height and color extremes on dry ground in the first row, where every dry
    // column is shaded as level, plus an empty column whose other fields are
    // all set and must not leak into the result.
    task automatic test_first_row_extremes();
        send_column(make_column(1, 1, 0, 24'hFFFFFF, 0, 16'h0000));
        send_column(make_column(0, 1, 2047, 24'h000000, 0, 16'hFFFF));
        send_column(make_column(0, 1, -2048, 24'hFFFFFF, 0, 16'h1234));
        send_column(make_column(0, 0, 2047, 24'hFFFFFF, 255, 16'hFFFF));
        send_column(make_column(0, 1, 1, 24'h800080, 0, 16'h8000));
    endtask

    // Water darkens by depth until the factor hits its floor; the depths around
    // the point where the floor takes over are the interesting ones.
    task automatic test_water_depths();
        int depths [9] = '{1, 13, 14, 15, 16, 17, 28, 128, 255};
        for (int i = 0; i < 9; i++) begin
            send_column(make_column(0, 1, i * 300 - 1200,
                                    (i % 2) ? 24'hFFFFFF : 24'h7F80FF, depths[i], i));
        end
    endtask

    // A tile start in the middle of a row puts the count back to column zero
    // and the first row, on dry and empty columns.
    task automatic test_tile_restart();
        send_column(make_column(1, 1, -1, 24'hA5A5A5, 0, 16'h0001));
        send_column(make_column(0, 0, -1, 24'h5A5A5A, 3, 16'hF00F));
        send_column(make_column(0, 1, 100, 24'h010203, 0, 16'h00FF));
        send_column(make_column(1, 0, 5, 24'hFFFFFF, 9, 16'hABCD));
        hold_until_drained();
    endtask

    // Random columns in raster order. Tile restarts are rare and held back until
    // the second row is under way, so most columns after the first row have a
    // real northern neighbor. Heights there mostly sit within one unit of
    // the north height, so higher, equal and lower all come up often.
    task automatic test_random_tiles();
        t_column c;
        int      col;
        bit      first;
        int      pick;
        for (int i = 0; i < RANDOM_COLUMNS; i++) begin
            c.start = !in_first_row && col_pos >= 96 && $urandom_range(0, 47) == 0;
            first   = c.start ? 1'b1 : in_first_row;
            col     = c.start ? 0 : col_pos;
            c.present = $urandom_range(0, 7) != 0;
            if (!first && north_heights[col].valid && $urandom_range(0, 9) < 7) begin
                c.height = north_heights[col].height + HEIGHT_W'($urandom_range(0, 2))
                           - HEIGHT_W'(1);
            end else begin
                c.height = HEIGHT_W'($urandom_range(0, 4095));
            end
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                c.depth = '0;
            end else if (pick < 16) begin
                c.depth = DEPTH_W'($urandom_range(1, 16));
            end else begin
                c.depth = DEPTH_W'($urandom_range(0, 255));
            end
            c.color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
            c.block = BLOCK_W'($urandom_range(0, 16'hFFFF));
            send_column(c);
            if (i == RANDOM_COLUMNS / 2) begin
                hold_until_drained();
            end
        end
    endtask

    // Receiver: each stall pattern runs for a random stretch before the next one is
    // picked. The choke pattern raises ready only at regular points, which bounds its longest stall.
    always @(posedge i_clk) begin
        if (sink_cycles_left == 0) begin
            sink_mode        = t_sink_mode'($urandom_range(0, 3));
            sink_cycles_left = $urandom_range(40, 160);
        end
        sink_cycles_left--;
        sink_phase++;
        case (sink_mode)
            SINK_OPEN: begin
                i_ready <= 1'b1;
            end
            SINK_COIN: begin
                i_ready <= $urandom_range(0, 1) == 1;
            end
            SINK_COMB: begin
                i_ready <= (sink_phase % 3) != 0;
            end
            default: begin
                i_ready <= (sink_phase % 10) == 0;
            end
        endcase
    end

    // Result checker: every accepted output beat is matched against the oldest
    // predicted pixel, field by field.
    always @(posedge i_clk) begin
        t_shaded want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("beat with nothing expected", o_pixel_argb, '0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_argb !== want.pixel) begin
                    report_mismatch("pixel_argb", o_pixel_argb, want.pixel);
                end
                if (o_height_valid !== want.hvalid) begin
                    report_mismatch("height_valid", 32'(o_height_valid), 32'(want.hvalid));
                end
                if (o_height_out !== want.height) begin
                    report_mismatch("height_out", 32'(o_height_out), 32'(want.height));
                end
                if (o_block_out !== want.block) begin
                    report_mismatch("block_out", 32'(o_block_out), 32'(want.block));
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL height_relief_shader");
            $finish;
        end
    end

    initial begin
        test_reset();
        test_first_row_extremes();
        test_water_depths();
        test_tile_restart();
        test_random_tiles();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("PASS height_relief_shader");
        end else begin
            $display("FAIL height_relief_shader");
        end
        $finish;
    end

endmodule
